// ===== hdl/udp_frame_receive_filter_assert.svh =====
// Assertion macros shared by the filter's modules.
// Both expect signals named clock and reset in the using scope.
`ifndef UDP_FRAME_RECEIVE_FILTER_ASSERT_SVH
`define UDP_FRAME_RECEIVE_FILTER_ASSERT_SVH

// cond holds -> prop holds in the same cycle
`define UFRF_ASSERT_IMPL(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// cond holds -> prop holds in the next cycle
`define UFRF_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== hdl/ufrf_pkg.sv =====
`default_nettype none

package ufrf_pkg;

   localparam int BUFFER_BYTES_DEFAULT = 256;
   localparam int QUEUE_DEPTH = 4;

   // header byte offsets
   localparam logic [15:0] OFF_ETYPE_HI  = 16'd12;
   localparam logic [15:0] OFF_ETYPE_LO  = 16'd13;
   localparam logic [15:0] OFF_PROTO     = 16'd23;
   localparam logic [15:0] OFF_SIP_0     = 16'd26;
   localparam logic [15:0] OFF_SIP_1     = 16'd27;
   localparam logic [15:0] OFF_SIP_2     = 16'd28;
   localparam logic [15:0] OFF_SIP_3     = 16'd29;
   localparam logic [15:0] OFF_SPORT_HI  = 16'd34;
   localparam logic [15:0] OFF_SPORT_LO  = 16'd35;
   localparam logic [15:0] OFF_DPORT_HI  = 16'd36;
   localparam logic [15:0] OFF_DPORT_LO  = 16'd37;
   localparam logic [15:0] OFF_ULEN_HI   = 16'd38;
   localparam logic [15:0] OFF_ULEN_LO   = 16'd39;
   localparam logic [15:0] PAYLOAD_START = 16'd42;
   localparam logic [15:0] OFFSET_MAX    = 16'hFFFF;

   localparam logic [7:0]  ETYPE_HI_VAL  = 8'h08;
   localparam logic [7:0]  ETYPE_LO_VAL  = 8'h00;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [15:0] UDP_HDR_BYTES = 16'd8;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [1:0] {
      CSR_SOURCE_IP   = 2'd0,
      CSR_SOURCE_PORT = 2'd1,
      CSR_DEST_PORT   = 2'd2,
      CSR_COPY_LIMIT  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  payload_byte;
      logic [7:0]  payload_index;
      logic        frame_matched;
      logic [15:0] payload_length;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] want_source_ip;
      logic [15:0] want_source_port;
      logic [15:0] want_dest_port;
      logic [15:0] copy_limit;
   } cfg_type;

   // words produced by one accepted byte; first is placed ahead of second in the queue
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } rsp_pair_type;

endpackage

`default_nettype wire

// ===== hdl/ufrf_core.sv =====
`default_nettype none
`include "udp_frame_receive_filter_assert.svh"

module ufrf_core #(
   parameter int BUFFER_BYTES = ufrf_pkg::BUFFER_BYTES_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire ufrf_pkg::req_type      req,
   input  wire ufrf_pkg::cfg_type      cfg,
   output ufrf_pkg::rsp_pair_type      push
);

   localparam int CNT_W = $clog2(BUFFER_BYTES);
   localparam logic [15:0] BUF_LIMIT = 16'(BUFFER_BYTES);

   logic [15:0]      offset_ff, offset_in;
   logic             matching_ff, matching_in;
   logic [15:0]      udp_length_ff, udp_length_in;
   logic [7:0]       port_shift_ff, port_shift_in;
   logic [CNT_W-1:0] copied_ff, copied_in;

   logic [15:0]      word;
   logic             match_now;
   logic [15:0]      udp_len_now;
   logic [7:0]       shift_now;
   logic [15:0]      body_len;
   logic [15:0]      copied_ext;
   logic             emit;
   logic             verdict_matched;
   ufrf_pkg::rsp_type payload_rsp, verdict_rsp;

   always_comb begin
      word        = {port_shift_ff, req.frame_byte};
      match_now   = matching_ff;
      udp_len_now = udp_length_ff;
      shift_now   = port_shift_ff;
      case (offset_ff)
         ufrf_pkg::OFF_ETYPE_HI: begin
            if (req.frame_byte != ufrf_pkg::ETYPE_HI_VAL) match_now = 1'b0;
         end
         ufrf_pkg::OFF_ETYPE_LO: begin
            if (req.frame_byte != ufrf_pkg::ETYPE_LO_VAL) match_now = 1'b0;
         end
         ufrf_pkg::OFF_PROTO: begin
            if (req.frame_byte != ufrf_pkg::PROTO_UDP) match_now = 1'b0;
         end
         ufrf_pkg::OFF_SIP_0: begin
            if (req.frame_byte != cfg.want_source_ip[31:24]) match_now = 1'b0;
         end
         ufrf_pkg::OFF_SIP_1: begin
            if (req.frame_byte != cfg.want_source_ip[23:16]) match_now = 1'b0;
         end
         ufrf_pkg::OFF_SIP_2: begin
            if (req.frame_byte != cfg.want_source_ip[15:8]) match_now = 1'b0;
         end
         ufrf_pkg::OFF_SIP_3: begin
            if (req.frame_byte != cfg.want_source_ip[7:0]) match_now = 1'b0;
         end
         ufrf_pkg::OFF_SPORT_HI, ufrf_pkg::OFF_DPORT_HI, ufrf_pkg::OFF_ULEN_HI: begin
            shift_now = req.frame_byte;
         end
         ufrf_pkg::OFF_SPORT_LO: begin
            if (word != cfg.want_source_port) match_now = 1'b0;
         end
         ufrf_pkg::OFF_DPORT_LO: begin
            if (word != cfg.want_dest_port) match_now = 1'b0;
         end
         ufrf_pkg::OFF_ULEN_LO: begin
            udp_len_now = word;
         end
         default: begin
         end
      endcase

      body_len   = udp_len_now - ufrf_pkg::UDP_HDR_BYTES;
      copied_ext = {{(16-CNT_W){1'b0}}, copied_ff};
      emit = (offset_ff >= ufrf_pkg::PAYLOAD_START) && match_now &&
             (offset_ff < BUF_LIMIT) && (copied_ext < cfg.copy_limit) &&
             (copied_ext < body_len);
      // frames ending before the UDP length is seen never match
      verdict_matched = match_now && (offset_ff >= ufrf_pkg::OFF_ULEN_LO);

      payload_rsp.item_kind      = ufrf_pkg::KIND_PAYLOAD;
      payload_rsp.payload_byte   = req.frame_byte;
      payload_rsp.payload_index  = copied_ext[7:0];
      payload_rsp.frame_matched  = 1'b0;
      payload_rsp.payload_length = 16'd0;
      payload_rsp.last           = ~req.frame_end;

      verdict_rsp.item_kind      = ufrf_pkg::KIND_VERDICT;
      verdict_rsp.payload_byte   = 8'd0;
      verdict_rsp.payload_index  = 8'd0;
      verdict_rsp.frame_matched  = verdict_matched;
      verdict_rsp.payload_length = verdict_matched ? body_len : 16'd0;
      verdict_rsp.last           = 1'b1;

      push.count  = accept ? {emit & req.frame_end, emit ^ req.frame_end} : 2'd0;
      push.first  = emit ? payload_rsp : verdict_rsp;
      push.second = verdict_rsp;

      offset_in     = offset_ff;
      matching_in   = matching_ff;
      udp_length_in = udp_length_ff;
      port_shift_in = port_shift_ff;
      copied_in     = copied_ff;
      if (accept) begin
         if (req.frame_end) begin
            offset_in     = 16'd0;
            matching_in   = 1'b1;
            udp_length_in = 16'd0;
            port_shift_in = 8'd0;
            copied_in     = '0;
         end else begin
            if (offset_ff != ufrf_pkg::OFFSET_MAX) offset_in = offset_ff + 16'd1;
            matching_in   = match_now;
            udp_length_in = udp_len_now;
            port_shift_in = shift_now;
            copied_in     = copied_ff + CNT_W'(emit);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= 16'd0;
         matching_ff   <= 1'b1;
         udp_length_ff <= 16'd0;
         port_shift_ff <= 8'd0;
         copied_ff     <= '0;
      end else begin
         offset_ff     <= offset_in;
         matching_ff   <= matching_in;
         udp_length_ff <= udp_length_in;
         port_shift_ff <= port_shift_in;
         copied_ff     <= copied_in;
      end
   end

   `UFRF_ASSERT_NEXT(a_end_clears, accept && req.frame_end, offset_ff == 16'd0 && matching_ff && copied_ff == '0, "frame state not cleared after last word")
   `UFRF_ASSERT_NEXT(a_idle_holds, !accept, $stable(offset_ff) && $stable(copied_ff), "frame state moved without an accepted word")

endmodule

`default_nettype wire

// ===== hdl/ufrf_queue.sv =====
`default_nettype none
`include "udp_frame_receive_filter_assert.svh"

module ufrf_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ufrf_pkg::rsp_pair_type push,
   output ufrf_pkg::rsp_type           rsp_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        room_two
);

   localparam int DEPTH  = ufrf_pkg::QUEUE_DEPTH;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   ufrf_pkg::rsp_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              pop;
   logic [PTR_W-1:0]  wr_next;

   always_comb begin
      rsp_valid = (fill_ff != '0);
      rsp_word  = mem_ff[rd_ff];
      pop       = rsp_valid && !rsp_stall;
      room_two  = (fill_ff <= FILL_W'(DEPTH - 2));
      wr_next   = wr_ff + PTR_W'(1);
      wr_in     = wr_ff + PTR_W'(push.count);
      rd_in     = rd_ff + PTR_W'(pop);
      fill_in   = fill_ff + FILL_W'(push.count) - FILL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem_ff[wr_ff] <= push.first;
      if (push.count == 2'd2) mem_ff[wr_next] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   `UFRF_ASSERT_IMPL(a_fill_bound, 1'b1, fill_ff <= FILL_W'(DEPTH), "queue fill beyond depth")
   `UFRF_ASSERT_IMPL(a_push_room, push.count != 2'd0, room_two, "words pushed without room")

endmodule

`default_nettype wire

// ===== hdl/udp_frame_receive_filter.sv =====
// UDP receive filter for Ethernet frames carrying IPv4.
// req_ channel: one frame byte per word, frame_end set on the last byte.
// A word is taken at a clock edge with req_valid high and req_stall low.
// rsp_ channel: payload bytes of frames whose EtherType, protocol, source
// address and ports match the csr_ registers, then one verdict word at the
// end of every frame; last marks the final word caused by one input byte.
// csr_ channel: write-only, always ready; index 0 source IP, 1 source port,
// 2 destination port, 3 copy limit. Write only between frames.
// The words of a byte accepted at an edge enter the output queue at that
// edge. Throughput: one byte per cycle while req_stall is low; a frame's
// last byte that also carries payload makes two words, which the four-entry
// output queue absorbs while bytes keep streaming. The queue sets the rate.
// req_stall rises when the queue lacks room for two words, so a stalled
// receiver backs up into req_stall once the queue holds more than two words.
// Reset (synchronous) empties the queue, clears the registers to zero and
// restarts the byte offset at the head of a frame.
`default_nettype none

module udp_frame_receive_filter #(
   parameter int BUFFER_BYTES = ufrf_pkg::BUFFER_BYTES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ufrf_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ufrf_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [31:0]       csr_data
);

   ufrf_pkg::cfg_type      cfg_ff, cfg_in;
   ufrf_pkg::rsp_pair_type push;
   logic                   room_two;
   logic                   req_accept;

   always_comb begin
      csr_ready  = 1'b1;
      req_stall  = ~room_two;
      req_accept = req_valid && room_two;
      cfg_in     = cfg_ff;
      if (csr_valid) begin
         case (ufrf_pkg::csr_index_type'(csr_index))
            ufrf_pkg::CSR_SOURCE_IP:   cfg_in.want_source_ip   = csr_data;
            ufrf_pkg::CSR_SOURCE_PORT: cfg_in.want_source_port = csr_data[15:0];
            ufrf_pkg::CSR_DEST_PORT:   cfg_in.want_dest_port   = csr_data[15:0];
            ufrf_pkg::CSR_COPY_LIMIT:  cfg_in.copy_limit       = csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ufrf_core #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .accept(req_accept),
      .req   (req_data),
      .cfg   (cfg_ff),
      .push  (push)
   );

   ufrf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .rsp_word (rsp_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .room_two (room_two)
   );

endmodule

`default_nettype wire

// ===== tb/udp_frame_receive_filter_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none

module udp_frame_receive_filter_checker #(
   parameter int BUFFER_BYTES = ufrf_pkg::BUFFER_BYTES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire ufrf_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire ufrf_pkg::rsp_type rsp_data,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [31:0]       csr_data,
   output int                     failures,
   output int                     pending,
   output int                     payload_words,
   output int                     verdict_words,
   output int                     matched_frames
);

   import ufrf_pkg::*;

   cfg_type     regs;
   logic [15:0] offset_q;
   logic        match_q;
   logic [15:0] udp_len_q;
   logic [7:0]  hi_byte_q;
   logic [15:0] copied_q;
   rsp_type     expected_words[$];

   initial begin
      failures       = 0;
      pending        = 0;
      payload_words  = 0;
      verdict_words  = 0;
      matched_frames = 0;
   end

   task automatic restart_frame();
      offset_q  = '0;
      match_q   = 1'b1;
      udp_len_q = '0;
      hi_byte_q = '0;
      copied_q  = '0;
   endtask

   task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
      failures++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
   endtask

   // advance the filter state by one byte and queue the words it should produce
   task automatic predict_byte(input req_type w);
      logic [7:0]  b;
      logic [15:0] off;
      logic [15:0] pair;
      logic [15:0] plen;
      rsp_type     r;
      b    = w.frame_byte;
      off  = offset_q;
      pair = {hi_byte_q, b};
      case (off)
         OFF_ETYPE_HI: if (b != ETYPE_HI_VAL) match_q = 1'b0;
         OFF_ETYPE_LO: if (b != ETYPE_LO_VAL) match_q = 1'b0;
         OFF_PROTO:    if (b != PROTO_UDP) match_q = 1'b0;
         OFF_SIP_0:    if (b != regs.want_source_ip[31:24]) match_q = 1'b0;
         OFF_SIP_1:    if (b != regs.want_source_ip[23:16]) match_q = 1'b0;
         OFF_SIP_2:    if (b != regs.want_source_ip[15:8]) match_q = 1'b0;
         OFF_SIP_3:    if (b != regs.want_source_ip[7:0]) match_q = 1'b0;
         OFF_SPORT_HI, OFF_DPORT_HI, OFF_ULEN_HI: hi_byte_q = b;
         OFF_SPORT_LO: if (pair != regs.want_source_port) match_q = 1'b0;
         OFF_DPORT_LO: if (pair != regs.want_dest_port) match_q = 1'b0;
         OFF_ULEN_LO:  udp_len_q = pair;
         default: ;
      endcase
      plen = udp_len_q - UDP_HDR_BYTES;
      if (off >= PAYLOAD_START && match_q && off < BUFFER_BYTES &&
          copied_q < regs.copy_limit && copied_q < plen) begin
         r               = '0;
         r.item_kind     = KIND_PAYLOAD;
         r.payload_byte  = b;
         r.payload_index = copied_q[7:0];
         r.last          = !w.frame_end;
         expected_words.push_back(r);
         copied_q++;
      end
      if (w.frame_end) begin
         r                = '0;
         r.item_kind      = KIND_VERDICT;
         r.frame_matched  = match_q && (off >= OFF_ULEN_LO);
         r.payload_length = r.frame_matched ? plen : 16'd0;
         r.last           = 1'b1;
         expected_words.push_back(r);
         restart_frame();
      end else if (offset_q != OFFSET_MAX) begin
         offset_q++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         regs = '0;
         restart_frame();
         expected_words.delete();
      end else begin
         // a byte taken at this edge still sees the old register values
         if (req_valid && !req_stall)
            predict_byte(req_data);
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_SOURCE_IP:   regs.want_source_ip   = csr_data;
               CSR_SOURCE_PORT: regs.want_source_port = csr_data[15:0];
               CSR_DEST_PORT:   regs.want_dest_port   = csr_data[15:0];
               CSR_COPY_LIMIT:  regs.copy_limit       = csr_data[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (rsp_data.item_kind === KIND_VERDICT) begin
               verdict_words++;
               if (rsp_data.frame_matched === 1'b1)
                  matched_frames++;
            end else begin
               payload_words++;
            end
            if (expected_words.size() == 0) begin
               flag("unexpected word", 32'h0, 32'(rsp_data));
            end else begin
               e = expected_words.pop_front();
               if (rsp_data.item_kind !== e.item_kind)
                  flag("item_kind", 32'(e.item_kind), 32'(rsp_data.item_kind));
               if (rsp_data.payload_byte !== e.payload_byte)
                  flag("payload_byte", 32'(e.payload_byte), 32'(rsp_data.payload_byte));
               if (rsp_data.payload_index !== e.payload_index)
                  flag("payload_index", 32'(e.payload_index), 32'(rsp_data.payload_index));
               if (rsp_data.frame_matched !== e.frame_matched)
                  flag("frame_matched", 32'(e.frame_matched), 32'(rsp_data.frame_matched));
               if (rsp_data.payload_length !== e.payload_length)
                  flag("payload_length", 32'(e.payload_length),
                       32'(rsp_data.payload_length));
               if (rsp_data.last !== e.last)
                  flag("last", 32'(e.last), 32'(rsp_data.last));
            end
         end
      end
      pending = expected_words.size();
   end

endmodule

`default_nettype wire

// ===== tb/udp_frame_receive_filter_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none

module udp_frame_receive_filter_tb;

   import ufrf_pkg::*;

   localparam int BUF_BYTES = BUFFER_BYTES_DEFAULT;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data  = '0;

   int failures;
   int pending;
   int payload_words;
   int verdict_words;
   int matched_frames;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int bytes_sent = 0;
   int frames_sent = 0;
   int settings_used = 0;

   logic [31:0] cur_ip;
   logic [15:0] cur_sport;
   logic [15:0] cur_dport;
   logic [7:0]  frame_buf[$];

   udp_frame_receive_filter #(.BUFFER_BYTES(BUF_BYTES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   udp_frame_receive_filter_checker #(.BUFFER_BYTES(BUF_BYTES)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .failures       (failures),
      .pending        (pending),
      .payload_words  (payload_words),
      .verdict_words  (verdict_words),
      .matched_frames (matched_frames)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   initial begin
      #1_000_000;
      $display("udp_frame_receive_filter_tb failed");
      $finish;
   end

   task automatic put_byte(input logic [7:0] b, input logic e);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req_type'({b, e});
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // drop valid and wait for every expected word
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_registers(input logic [31:0] ip, input logic [15:0] sp,
                                input logic [15:0] dp, input logic [15:0] lim);
      quiesce();
      write_reg(CSR_SOURCE_IP, ip);
      write_reg(CSR_SOURCE_PORT, {16'h0, sp});
      write_reg(CSR_DEST_PORT, {16'h0, dp});
      write_reg(CSR_COPY_LIMIT, {16'h0, lim});
      cur_ip    = ip;
      cur_sport = sp;
      cur_dport = dp;
      settings_used++;
   endtask

   task automatic choose_setting();
      logic [31:0] ip;
      logic [15:0] sp;
      logic [15:0] dp;
      logic [15:0] lim;
      case ($urandom_range(3))
         0: ip = 32'h0;
         1: ip = 32'hFFFF_FFFF;
         default: ip = $urandom;
      endcase
      case ($urandom_range(3))
         0: sp = 16'h0;
         1: sp = 16'hFFFF;
         default: sp = 16'($urandom_range(16'hFFFF));
      endcase
      case ($urandom_range(3))
         0: dp = 16'h0;
         1: dp = 16'hFFFF;
         default: dp = 16'($urandom_range(16'hFFFF));
      endcase
      case ($urandom_range(7))
         0: lim = 16'h0;
         1: lim = 16'h1;
         2, 3: lim = 16'hFFFF;
         default: lim = 16'($urandom_range(40));
      endcase
      set_registers(ip, sp, dp, lim);
   endtask

   // well-formed header from the current registers, optional bad field
   task automatic build_frame(input int pay_n, input bit flaw, input int len_mode);
      logic [15:0] ulen;
      logic [7:0]  flip;
      int          pos;
      frame_buf.delete();
      repeat (12) frame_buf.push_back(8'($urandom_range(255)));
      frame_buf.push_back(ETYPE_HI_VAL);
      frame_buf.push_back(ETYPE_LO_VAL);
      repeat (9) frame_buf.push_back(8'($urandom_range(255)));
      frame_buf.push_back(PROTO_UDP);
      repeat (2) frame_buf.push_back(8'($urandom_range(255)));
      frame_buf.push_back(cur_ip[31:24]);
      frame_buf.push_back(cur_ip[23:16]);
      frame_buf.push_back(cur_ip[15:8]);
      frame_buf.push_back(cur_ip[7:0]);
      repeat (4) frame_buf.push_back(8'($urandom_range(255)));
      frame_buf.push_back(cur_sport[15:8]);
      frame_buf.push_back(cur_sport[7:0]);
      frame_buf.push_back(cur_dport[15:8]);
      frame_buf.push_back(cur_dport[7:0]);
      case (len_mode)
         6, 7: ulen = 16'($urandom_range(16'hFFFF));
         8:    ulen = 16'($urandom_range(15));
         9:    ulen = 16'(pay_n + 8 + int'($urandom_range(6)) - 3);
         default: ulen = 16'(pay_n + 8);
      endcase
      frame_buf.push_back(ulen[15:8]);
      frame_buf.push_back(ulen[7:0]);
      repeat (2) frame_buf.push_back(8'($urandom_range(255)));
      repeat (pay_n) frame_buf.push_back(8'($urandom_range(255)));
      if (flaw) begin
         case ($urandom_range(10))
            0: pos = int'(OFF_ETYPE_HI);
            1: pos = int'(OFF_ETYPE_LO);
            2: pos = int'(OFF_PROTO);
            3: pos = int'(OFF_SIP_0);
            4: pos = int'(OFF_SIP_1);
            5: pos = int'(OFF_SIP_2);
            6: pos = int'(OFF_SIP_3);
            7: pos = int'(OFF_SPORT_HI);
            8: pos = int'(OFF_SPORT_LO);
            9: pos = int'(OFF_DPORT_HI);
            default: pos = int'(OFF_DPORT_LO);
         endcase
         flip = 8'($urandom_range(1, 255));
         frame_buf[pos] = frame_buf[pos] ^ flip;
      end
   endtask

   task automatic shorten_frame(input int n);
      while (frame_buf.size() > n) void'(frame_buf.pop_back());
   endtask

   // send frame_buf[from .. upto-1]; the frame ends only with its last byte
   task automatic send_range(input int from, input int upto);
      for (int i = from; i < upto; i++)
         put_byte(frame_buf[i], i == frame_buf.size() - 1);
      if (upto == frame_buf.size())
         frames_sent++;
   endtask

   task automatic send_frame();
      send_range(0, frame_buf.size());
   endtask

   task automatic random_frame();
      int sel;
      int pay_n;
      sel = $urandom_range(99);
      if (sel < 65) begin
         pay_n = ($urandom_range(9) == 0) ? $urandom_range(150, 260) : $urandom_range(40);
         build_frame(pay_n, 1'b0, $urandom_range(9));
      end else if (sel < 80) begin
         build_frame($urandom_range(30), 1'b1, $urandom_range(9));
      end else if (sel < 90) begin
         build_frame(0, 1'b0, 0);
         shorten_frame($urandom_range(1, 41));
      end else begin
         frame_buf.delete();
         repeat ($urandom_range(1, 60)) frame_buf.push_back(8'($urandom_range(255)));
      end
      send_frame();
   endtask

   task automatic random_phase(input int byte_goal);
      int start_bytes;
      int n;
      start_bytes = bytes_sent;
      n = 0;
      while (bytes_sent - start_bytes < byte_goal) begin
         if (n % 12 == 0)
            choose_setting();
         random_frame();
         n++;
      end
   endtask

   initial begin
      cur_ip    = '0;
      cur_sport = '0;
      cur_dport = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct  = 16;
      recv_stall_pct = 75;

      // single-byte frames under reset registers, both byte extremes
      frame_buf = '{8'hFF};
      send_frame();
      frame_buf = '{8'h00};
      send_frame();

      set_registers($urandom, 16'hFFFF, 16'h0000, 16'hFFFF);
      // ends one byte before the length field is complete
      build_frame(0, 1'b0, 0);
      shorten_frame(int'(OFF_ULEN_LO));
      send_frame();
      // ends exactly on the length field, empty payload
      build_frame(0, 1'b0, 0);
      shorten_frame(int'(OFF_ULEN_LO) + 1);
      send_frame();
      // UDP length below 8 wraps; last byte also carries payload
      build_frame(4, 1'b0, 8);
      frame_buf[OFF_ULEN_HI] = 8'h00;
      frame_buf[OFF_ULEN_LO] = 8'h03;
      send_frame();

      // register rewritten between bytes of a frame
      build_frame(5, 1'b0, 0);
      set_registers(~frame_buf.size() ^ cur_ip, cur_sport, cur_dport, 16'd1);
      send_range(0, 20);
      quiesce();
      write_reg(CSR_SOURCE_IP, {frame_buf[OFF_SIP_0], frame_buf[OFF_SIP_1],
                                frame_buf[OFF_SIP_2], frame_buf[OFF_SIP_3]});
      cur_ip = {frame_buf[OFF_SIP_0], frame_buf[OFF_SIP_1],
                frame_buf[OFF_SIP_2], frame_buf[OFF_SIP_3]};
      send_range(20, frame_buf.size());

      random_phase(450);

      send_idle_pct  = 75;
      recv_stall_pct = 16;
      random_phase(450);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_phase(450);

      quiesce();
      repeat (20) @(negedge clock);
      $display("covered %0d bytes in %0d frames over %0d register settings",
               bytes_sent, frames_sent, settings_used);
      $display("checked %0d payload words and %0d verdicts (%0d matched)",
               payload_words, verdict_words, matched_frames);
      if (failures == 0 && pending == 0) begin
         $display("udp_frame_receive_filter_tb passed");
      end else begin
         $display("udp_frame_receive_filter_tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/ufrf_pkg.sv
hdl/ufrf_core.sv
hdl/ufrf_queue.sv
hdl/udp_frame_receive_filter.sv
tb/udp_frame_receive_filter_checker.sv
tb/udp_frame_receive_filter_tb.sv
